FILE: src/tcpq_pkg.sv
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared types and codes of the two-class priority queue.
// ----------------------------------------------------------------------------
package tcpq_pkg;

  localparam int TAG_W   = 16;
  localparam int AGE_W   = 8;
  localparam int CAP_W   = 5;
  localparam int REG_IDX_W = 1;

  // Request kinds
  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_ENQUEUED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_DEQUEUED = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_NORMAL_CAP = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_URGENT_CAP = 1'b1;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
  } entry_t;

  typedef struct packed {
    logic             kind;
    logic             is_urgent;
    logic [TAG_W-1:0] entry_tag;
    logic [AGE_W-1:0] entry_age;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [TAG_W-1:0] out_tag;
    logic [AGE_W-1:0] out_age;
    logic             out_was_urgent;
    logic             next_valid;
    logic [TAG_W-1:0] next_tag;
    logic [AGE_W-1:0] next_age;
    logic             all_empty;
  } rsp_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0] reg_idx;
    logic [CAP_W-1:0]     wdata;
  } cfg_t;

endpackage

FILE: src/tcpq_chan_if.sv
// ----------------------------------------------------------------------------
// tcpq_chan_if
// Valid/ready channel carrying one payload word per transfer.
// ----------------------------------------------------------------------------
interface tcpq_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/two_class_priority_queue.sv
// ----------------------------------------------------------------------------
// two_class_priority_queue
// Strict-priority queue with an urgent and a normal class, each kept in a
// synchronous memory with front/rear pointers.
// ----------------------------------------------------------------------------
// Usage:
//   req_i  : one request per transfer (enqueue with class, tag, age; or
//            dequeue). Taken only while the block is idle.
//   rsp_o  : one result per request: status, dequeued entry, the entry to be
//            served next and an all-empty flag.
//   cfg_i  : capacity register writes, always ready; write only while idle.
// Sequence: a request is taken in S_IDLE, where the pointers are updated and the
//   dequeued head is read; the new head is read from the memory in S_HEAD, and
//   the result register loads in S_FIN. A new request is taken only after the
//   result register has loaded, once the block is back in S_IDLE.
// Reset: both queues empty, capacities 16. Memory contents are not cleared.
// Stall: while rsp_o is held by the receiver, the next request is still taken
//   and worked up to its last cycle, where it waits for the output register.
// ----------------------------------------------------------------------------
module two_class_priority_queue #(
  parameter int URGENT_DEPTH = 16,
  parameter int NORMAL_DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  tcpq_chan_if.sink                           req_i,
  tcpq_chan_if.source                         rsp_o,
  tcpq_chan_if.sink                           cfg_i
);
  import tcpq_pkg::*;

  localparam int UPW = (URGENT_DEPTH > 1) ? $clog2(URGENT_DEPTH) : 1;
  localparam int NPW = (NORMAL_DEPTH > 1) ? $clog2(NORMAL_DEPTH) : 1;
  localparam int UCW = (UPW + 1 > CAP_W) ? UPW + 1 : CAP_W;
  localparam int NCW = (NPW + 1 > CAP_W) ? NPW + 1 : CAP_W;
  localparam logic [UCW-1:0] U_DEPTH_C = UCW'(URGENT_DEPTH);
  localparam logic [NCW-1:0] N_DEPTH_C = NCW'(NORMAL_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HEAD = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_q, state_d;

  // Configuration
  logic [CAP_W-1:0] ncap_q, ucap_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncap_q <= CAP_RESET;
      ucap_q <= CAP_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.reg_idx)
        REG_NORMAL_CAP: ncap_q <= cfg_i.data.wdata;
        REG_URGENT_CAP: ucap_q <= cfg_i.data.wdata;
        default: ;
      endcase
    end
  end

  // Queue pointers
  logic           u_valid_q, u_valid_d, n_valid_q, n_valid_d;
  logic [UPW-1:0] u_front_q, u_front_d, u_rear_q, u_rear_d, u_rear_nx;
  logic [NPW-1:0] n_front_q, n_front_d, n_rear_q, n_rear_d, n_rear_nx;
  logic [UCW-1:0] u_cap_ext, u_usable, u_used;
  logic [NCW-1:0] n_cap_ext, n_usable, n_used;
  logic [UPW:0]   u_front_inc;
  logic [NPW:0]   n_front_inc;
  logic           u_push_ok, n_push_ok;

  assign u_cap_ext = UCW'(ucap_q);
  assign n_cap_ext = NCW'(ncap_q);
  assign u_usable  = (u_cap_ext < U_DEPTH_C) ? u_cap_ext : U_DEPTH_C;
  assign n_usable  = (n_cap_ext < N_DEPTH_C) ? n_cap_ext : N_DEPTH_C;
  assign u_used    = u_valid_q ? UCW'(u_rear_q) + UCW'(1) : '0;
  assign n_used    = n_valid_q ? NCW'(n_rear_q) + NCW'(1) : '0;
  assign u_push_ok = u_used < u_usable;
  assign n_push_ok = n_used < n_usable;
  assign u_rear_nx = u_valid_q ? UPW'(u_rear_q + UPW'(1)) : '0;
  assign n_rear_nx = n_valid_q ? NPW'(n_rear_q + NPW'(1)) : '0;
  assign u_front_inc = {1'b0, u_front_q} + (UPW + 1)'(1);
  assign n_front_inc = {1'b0, n_front_q} + (NPW + 1)'(1);

  // Request decode
  logic in_fire, enq, deq, u_we, n_we, u_pop, n_pop, u_re, n_re;
  logic out_valid_q, out_load;

  assign req_i.ready = (state_q == S_IDLE);
  assign in_fire = req_i.valid && req_i.ready;
  assign enq   = in_fire && (req_i.data.kind == KIND_ENQ);
  assign deq   = in_fire && (req_i.data.kind == KIND_DEQ);
  assign u_we  = enq && req_i.data.is_urgent && u_push_ok;
  assign n_we  = enq && !req_i.data.is_urgent && n_push_ok;
  assign u_pop = deq && u_valid_q;
  assign n_pop = deq && !u_valid_q && n_valid_q;
  // Both reads address the current front: the served head at accept, the
  // new head in S_HEAD, once the pointers have moved.
  assign u_re  = u_pop || ((state_q == S_HEAD) && u_valid_q);
  assign n_re  = n_pop || ((state_q == S_HEAD) && !u_valid_q && n_valid_q);

  always_comb begin
    u_valid_d = u_valid_q;
    u_front_d = u_front_q;
    u_rear_d  = u_rear_q;
    n_valid_d = n_valid_q;
    n_front_d = n_front_q;
    n_rear_d  = n_rear_q;
    if (u_we) begin
      u_valid_d = 1'b1;
      u_rear_d  = u_rear_nx;
      if (!u_valid_q) u_front_d = '0;
    end
    if (n_we) begin
      n_valid_d = 1'b1;
      n_rear_d  = n_rear_nx;
      if (!n_valid_q) n_front_d = '0;
    end
    if (u_pop) begin
      if (u_front_inc > {1'b0, u_rear_q}) begin
        u_valid_d = 1'b0;
        u_front_d = '0;
        u_rear_d  = '0;
      end else begin
        u_front_d = u_front_inc[UPW-1:0];
      end
    end
    if (n_pop) begin
      if (n_front_inc > {1'b0, n_rear_q}) begin
        n_valid_d = 1'b0;
        n_front_d = '0;
        n_rear_d  = '0;
      end else begin
        n_front_d = n_front_inc[NPW-1:0];
      end
    end
  end

  // Entry memories
  entry_t u_mem [URGENT_DEPTH];
  entry_t n_mem [NORMAL_DEPTH];
  entry_t u_rdata_q, n_rdata_q, wentry;

  assign wentry = '{tag: req_i.data.entry_tag, age: req_i.data.entry_age};

  always_ff @(posedge clk_i) begin
    if (u_we) u_mem[u_rear_nx] <= wentry;
    if (u_re) u_rdata_q <= u_mem[u_front_q];
  end

  always_ff @(posedge clk_i) begin
    if (n_we) n_mem[n_rear_nx] <= wentry;
    if (n_re) n_rdata_q <= n_mem[n_front_q];
  end

  // Sequencer
  assign out_load = (state_q == S_FIN) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = S_HEAD;
      S_HEAD:  state_d = S_FIN;
      S_FIN:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      u_valid_q   <= 1'b0;
      u_front_q   <= '0;
      u_rear_q    <= '0;
      n_valid_q   <= 1'b0;
      n_front_q   <= '0;
      n_rear_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      u_valid_q <= u_valid_d;
      u_front_q <= u_front_d;
      u_rear_q  <= u_rear_d;
      n_valid_q <= n_valid_d;
      n_front_q <= n_front_d;
      n_rear_q  <= n_rear_d;
      if (out_load)          out_valid_q <= 1'b1;
      else if (rsp_o.ready)  out_valid_q <= 1'b0;
    end
  end

  // Result payload
  logic [1:0] status_q;
  logic       served_urg_q, next_valid_q, next_urg_q;
  entry_t     deq_entry_q, head;
  rsp_t       rsp_q;

  always_comb begin
    head = '0;
    if (next_valid_q) head = next_urg_q ? u_rdata_q : n_rdata_q;
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      served_urg_q <= u_pop;
      if (enq)                        status_q <= (u_we || n_we) ? ST_ENQUEUED : ST_FULL;
      else if (u_valid_q || n_valid_q) status_q <= ST_DEQUEUED;
      else                            status_q <= ST_EMPTY;
    end
    if (state_q == S_HEAD) begin
      if (status_q == ST_DEQUEUED) deq_entry_q <= served_urg_q ? u_rdata_q : n_rdata_q;
      else                         deq_entry_q <= '0;
      next_valid_q <= u_valid_q || n_valid_q;
      next_urg_q   <= u_valid_q;
    end
    if (out_load) begin
      rsp_q.status         <= status_q;
      rsp_q.out_tag        <= deq_entry_q.tag;
      rsp_q.out_age        <= deq_entry_q.age;
      rsp_q.out_was_urgent <= (status_q == ST_DEQUEUED) && served_urg_q;
      rsp_q.next_valid     <= next_valid_q;
      rsp_q.next_tag       <= head.tag;
      rsp_q.next_age       <= head.age;
      rsp_q.all_empty      <= !next_valid_q;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = rsp_q;

  // Checks
  a_u_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    u_valid_q |-> (u_front_q <= u_rear_q))
    else $error("urgent front passed rear");

  a_n_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_valid_q |-> (n_front_q <= n_rear_q))
    else $error("normal front passed rear");

  a_empty_deq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HEAD && status_q == ST_EMPTY) |-> (!u_valid_q && !n_valid_q))
    else $error("empty dequeue left a queue valid");

endmodule
